FILE: rtl/core/spvg_pkg.sv
package spvg_pkg;

	localparam int NUM_W        = 19;
	localparam int CORDIC_STEPS = 24;
	localparam int MAX_SUBDIV   = 256;

	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

	localparam logic CFG_SUBDIV = 1'b0;
	localparam logic CFG_RADIUS = 1'b1;

	typedef struct packed {
		logic valid;
		logic last;
		logic ring0;
		logic ovf_t;
		logic rho_big;
	} div_side_t;

	typedef struct packed {
		logic        valid;
		logic        last;
		logic [1:0]  quad_t;
		logic [1:0]  quad_r;
		logic [15:0] tex_s;
		logic [16:0] tex_t;
	} cord_side_t;

	// arctangent of 2^-k in units of 2^-32 turn
	function automatic logic signed [31:0] atan_turn(input int step);
		logic signed [31:0] a;
		unique case (step)
			0:  a = 32'sd536870912;
			1:  a = 32'sd316933406;
			2:  a = 32'sd167458907;
			3:  a = 32'sd85004756;
			4:  a = 32'sd42667331;
			5:  a = 32'sd21354465;
			6:  a = 32'sd10680862;
			7:  a = 32'sd5340245;
			8:  a = 32'sd2670163;
			9:  a = 32'sd1335087;
			10: a = 32'sd667544;
			11: a = 32'sd333772;
			12: a = 32'sd166886;
			13: a = 32'sd83443;
			14: a = 32'sd41722;
			15: a = 32'sd20861;
			16: a = 32'sd10430;
			17: a = 32'sd5215;
			18: a = 32'sd2608;
			19: a = 32'sd1304;
			20: a = 32'sd652;
			21: a = 32'sd326;
			22: a = 32'sd163;
			23: a = 32'sd81;
			default: a = 32'sd0;
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/core/spvg_div_cell.sv
// one restoring-division bit; requires rem < dvs
module spvg_div_cell #(
	parameter int QW = 16
) (
	input  logic                        clk,
	input  logic [spvg_pkg::NUM_W-1:0]  rem,
	input  logic [QW-1:0]               quo,
	input  logic [spvg_pkg::NUM_W-1:0]  dvs,
	output logic [spvg_pkg::NUM_W-1:0]  next_rem,
	output logic [QW-1:0]               next_quo
);

	logic [spvg_pkg::NUM_W:0]   dbl;
	logic [spvg_pkg::NUM_W:0]   diff;
	logic                       ge;
	logic [spvg_pkg::NUM_W-1:0] rem_q;
	logic [QW-1:0]              quo_q;

	always_comb begin
		dbl  = {rem, 1'b0};
		diff = dbl - {1'b0, dvs};
		ge   = dbl >= {1'b0, dvs};
	end

	always_ff @(posedge clk) begin
		rem_q <= ge ? diff[spvg_pkg::NUM_W-1:0] : dbl[spvg_pkg::NUM_W-1:0];
		quo_q <= {quo[QW-2:0], ge};
	end

	assign next_rem = rem_q;
	assign next_quo = quo_q;

endmodule

FILE: rtl/core/spvg_cordic_cell.sv
module spvg_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic signed [31:0] x,
	input  logic signed [31:0] y,
	input  logic signed [31:0] z,
	output logic signed [31:0] next_x,
	output logic signed [31:0] next_y,
	output logic signed [31:0] next_z
);

	localparam logic signed [31:0] ATAN = spvg_pkg::atan_turn(STEP);

	logic signed [31:0] dx;
	logic signed [31:0] dy;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [31:0] z_q;

	assign dx = y >>> STEP;
	assign dy = x >>> STEP;

	always_ff @(posedge clk) begin
		if (!z[31]) begin
			x_q <= x - dx;
			y_q <= y + dy;
			z_q <= z - ATAN;
		end else begin
			x_q <= x + dx;
			y_q <= y - dy;
			z_q <= z + ATAN;
		end
	end

	assign next_x = x_q;
	assign next_y = y_q;
	assign next_z = z_q;

endmodule

FILE: rtl/core/spiral_sphere_vertex_generator.sv
// Output order: for a taken start the lower-ring vertex has done high first, the
// upper-ring vertex in the cycle after it.
// Throughput: start is taken only while busy is low, as both vertices share one result port; the
// divider and CORDIC chains take a new vertex every cycle. busy is high for one cycle.
// Reset: pipeline emptied, subdivisions = 60, radius_q8 = 256. No clearing pass.
// Results cannot be stalled by the receiver.
module spiral_sphere_vertex_generator #(
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [8:0]         ring_index,
	input  logic [8:0]         segment_index,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output logic signed [24:0] pos_x,
	output logic signed [24:0] pos_y,
	output logic signed [24:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [15:0]        tex_s,
	output logic [16:0]        tex_t,
	output logic               last_of_pair
);

	localparam int AB = ANGLE_BITS;
	localparam int NW = spvg_pkg::NUM_W;
	localparam int CS = spvg_pkg::CORDIC_STEPS;
	localparam int JW = 9;
	localparam int TQ = AB + JW;
	localparam logic [AB-1:0] HALF = AB'(1) << (AB - 1);

	// configuration
	logic [8:0]    n_q;
	logic [NW-1:0] dvs2_q;
	logic [15:0]   radius_q;
	logic [8:0]    n_new;
	logic [17:0]   nsq_new;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data[8:0] == 9'd0)
			n_new = 9'd1;
		else if (cfg_data[8:0] > 9'(spvg_pkg::MAX_SUBDIV))
			n_new = 9'(spvg_pkg::MAX_SUBDIV);
		else
			n_new = cfg_data[8:0];
		nsq_new = n_new * n_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= 9'd60;
			dvs2_q   <= NW'(7200);
			radius_q <= 16'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				spvg_pkg::CFG_SUBDIV: begin
					n_q    <= n_new;
					dvs2_q <= {nsq_new, 1'b0};
				end
				spvg_pkg::CFG_RADIUS: radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// issue: lower-ring vertex on transfer, upper-ring vertex next cycle
	logic       acc;
	logic       pend_q;
	logic [8:0] ri_q;
	logic [8:0] sj_q;
	logic [8:0] km1;
	logic [8:0] jx;
	logic [17:0] kn;

	assign acc  = start && !pend_q;
	assign busy = pend_q;

	always_comb begin
		km1 = pend_q ? ri_q - 9'd1 : ring_index;
		jx  = pend_q ? sj_q : segment_index;
		kn  = km1 * n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= 1'b0;
		else
			pend_q <= acc;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ri_q <= ring_index;
			sj_q <= segment_index;
		end
	end

	// stage 1
	logic [NW-1:0]       num_s1;
	logic [8:0]          j_s1;
	spvg_pkg::div_side_t sd_s1;
	spvg_pkg::div_side_t sd1_nx;

	always_comb begin
		sd1_nx       = '0;
		sd1_nx.valid = acc || pend_q;
		sd1_nx.last  = pend_q;
		sd1_nx.ring0 = pend_q && (ri_q == 9'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sd_s1 <= '0;
		else
			sd_s1 <= sd1_nx;
	end

	always_ff @(posedge clk) begin
		num_s1 <= NW'(kn) + NW'(jx);
		j_s1   <= jx;
	end

	// stage 2: divider set-up
	logic          rho_big;
	logic          ovf_t;
	logic [NW-1:0] rem_t_s2;
	logic [NW-1:0] rem_r_s2;
	spvg_pkg::div_side_t sd_s2;
	spvg_pkg::div_side_t sd2_nx;

	always_comb begin
		rho_big = num_s1 >= dvs2_q;
		ovf_t   = {1'b0, j_s1} >= {n_q, 1'b0};
		sd2_nx         = sd_s1;
		sd2_nx.ovf_t   = ovf_t;
		sd2_nx.rho_big = rho_big;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sd_s2 <= '0;
		else
			sd_s2 <= sd2_nx;
	end

	always_ff @(posedge clk) begin
		rem_t_s2 <= NW'(j_s1);
		rem_r_s2 <= (rho_big || sd_s1.ring0) ? '0 : num_s1;
	end

	// divider chains: theta = j*2^AB/n, rho = num*2^AB/(2n^2)
	// theta divides j by n<<9 over 9 extra steps so j may exceed n;
	// rho is held back by the rd_s delay registers to stay aligned
	logic [NW-1:0] dvs_t;
	logic [NW-1:0] rt_s [TQ+1];
	logic [NW-1:0] rd_s [JW+1];
	logic [NW-1:0] rr_s [AB+1];
	logic [TQ-1:0] qt_s [TQ+1];
	logic [AB-1:0] qr_s [AB+1];
	spvg_pkg::div_side_t dsd_s [TQ+1];

	assign dvs_t    = NW'({n_q, 9'b0});
	assign rt_s[0]  = rem_t_s2;
	assign rd_s[0]  = rem_r_s2;
	assign rr_s[0]  = rd_s[JW];
	assign qt_s[0]  = '0;
	assign qr_s[0]  = '0;
	assign dsd_s[0] = sd_s2;

	for (genvar k = 0; k < TQ; k++) begin : g_div_t
		spvg_div_cell #(.QW(TQ)) u_dt (
			.clk      (clk),
			.rem      (rt_s[k]),
			.quo      (qt_s[k]),
			.dvs      (dvs_t),
			.next_rem (rt_s[k+1]),
			.next_quo (qt_s[k+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dsd_s[k+1] <= '0;
			else
				dsd_s[k+1] <= dsd_s[k];
		end
	end

	for (genvar k = 0; k < JW; k++) begin : g_rdly
		always_ff @(posedge clk) begin
			rd_s[k+1] <= rd_s[k];
		end
	end

	for (genvar k = 0; k < AB; k++) begin : g_div_r
		spvg_div_cell #(.QW(AB)) u_dr (
			.clk      (clk),
			.rem      (rr_s[k]),
			.quo      (qr_s[k]),
			.dvs      (dvs2_q),
			.next_rem (rr_s[k+1]),
			.next_quo (qr_s[k+1])
		);
	end

	// stage 3: angles, texture coordinates, CORDIC set-up
	spvg_pkg::div_side_t dend;
	logic [TQ-1:0]  theta;
	logic [TQ+14:0] ts_wide;
	logic [AB-1:0]  rho;
	logic [AB+16:0] tt_wide;
	logic [31:0]    ang_t;
	logic [31:0]    ang_r;
	logic [15:0]    ts;
	logic [16:0]    tt;

	always_comb begin
		dend    = dsd_s[TQ];
		theta   = qt_s[TQ];
		ts_wide = {theta, 15'b0} >> AB;
		ts      = dend.ovf_t ? 16'hFFFF : ts_wide[15:0];
		if (dend.ring0)
			rho = '0;
		else if (dend.rho_big || qr_s[AB] > HALF)
			rho = HALF;
		else
			rho = qr_s[AB];
		tt_wide = {rho, 17'b0} >> AB;
		tt      = 17'd65536 - tt_wide[16:0];
		ang_t   = 32'(theta[AB-1:0]) << (32 - AB);
		ang_r   = 32'(rho) << (32 - AB);
	end

	logic signed [31:0] tx_s [CS+1];
	logic signed [31:0] ty_s [CS+1];
	logic signed [31:0] tz_s [CS+1];
	logic signed [31:0] rx_s [CS+1];
	logic signed [31:0] ry_s [CS+1];
	logic signed [31:0] rz_s [CS+1];
	spvg_pkg::cord_side_t csd_s [CS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csd_s[0] <= '0;
		end else begin
			csd_s[0].valid  <= dend.valid;
			csd_s[0].last   <= dend.last;
			csd_s[0].quad_t <= ang_t[31:30];
			csd_s[0].quad_r <= ang_r[31:30];
			csd_s[0].tex_s  <= ts;
			csd_s[0].tex_t  <= tt;
		end
	end

	always_ff @(posedge clk) begin
		tx_s[0] <= spvg_pkg::CORDIC_GAIN;
		ty_s[0] <= '0;
		tz_s[0] <= {2'b00, ang_t[29:0]};
		rx_s[0] <= spvg_pkg::CORDIC_GAIN;
		ry_s[0] <= '0;
		rz_s[0] <= {2'b00, ang_r[29:0]};
	end

	for (genvar k = 0; k < CS; k++) begin : g_cordic
		spvg_cordic_cell #(.STEP(k)) u_ct (
			.clk    (clk),
			.x      (tx_s[k]),
			.y      (ty_s[k]),
			.z      (tz_s[k]),
			.next_x (tx_s[k+1]),
			.next_y (ty_s[k+1]),
			.next_z (tz_s[k+1])
		);
		spvg_cordic_cell #(.STEP(k)) u_cr (
			.clk    (clk),
			.x      (rx_s[k]),
			.y      (ry_s[k]),
			.z      (rz_s[k]),
			.next_x (rx_s[k+1]),
			.next_y (ry_s[k+1]),
			.next_z (rz_s[k+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				csd_s[k+1] <= '0;
			else
				csd_s[k+1] <= csd_s[k];
		end
	end

	// stage 4: quadrant fold and direction products
	logic signed [32:0] ct;
	logic signed [32:0] st;
	logic signed [32:0] cr;
	logic signed [32:0] sr;
	logic signed [32:0] xt;
	logic signed [32:0] yt;
	logic signed [32:0] xr;
	logic signed [32:0] yr;

	always_comb begin
		xt = 33'(tx_s[CS]);
		yt = 33'(ty_s[CS]);
		xr = 33'(rx_s[CS]);
		yr = 33'(ry_s[CS]);
		case (csd_s[CS].quad_t)
			2'd0:    begin ct = xt;  st = yt;  end
			2'd1:    begin ct = -yt; st = xt;  end
			2'd2:    begin ct = -xt; st = -yt; end
			default: begin ct = yt;  st = -xt; end
		endcase
		case (csd_s[CS].quad_r)
			2'd0:    begin cr = xr;  sr = yr;  end
			2'd1:    begin cr = -yr; sr = xr;  end
			2'd2:    begin cr = -xr; sr = -yr; end
			default: begin cr = yr;  sr = -xr; end
		endcase
	end

	logic signed [65:0] pa_s4;
	logic signed [65:0] pb_s4;
	logic signed [32:0] cr_s4;
	spvg_pkg::cord_side_t sd_s4;
	spvg_pkg::cord_side_t sd_s5;
	spvg_pkg::cord_side_t sd_s6;

	always_ff @(posedge clk) begin
		pa_s4 <= -(st * sr);
		pb_s4 <= ct * sr;
		cr_s4 <= cr;
	end

	// stage 5: back to Q1.30
	logic signed [65:0] ra;
	logic signed [65:0] rb;
	logic signed [33:0] p_s5 [3];

	always_comb begin
		ra = (pa_s4 + (66'sd1 <<< 29)) >>> 30;
		rb = (pb_s4 + (66'sd1 <<< 29)) >>> 30;
	end

	always_ff @(posedge clk) begin
		p_s5[0] <= ra[33:0];
		p_s5[1] <= rb[33:0];
		p_s5[2] <= 34'(cr_s4);
	end

	// stage 6: scale by radius, round normals
	logic signed [50:0] pp_s6  [3];
	logic signed [15:0] nrm_s6 [3];
	logic signed [33:0] nv     [3];
	logic signed [15:0] nsat   [3];

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			nv[m] = (p_s5[m] + 34'sd16384) >>> 15;
			if (radius_q == 16'd0)
				nsat[m] = '0;
			else if (nv[m] > 34'sd32767)
				nsat[m] = 16'sh7FFF;
			else if (nv[m] < -34'sd32768)
				nsat[m] = -16'sh8000;
			else
				nsat[m] = nv[m][15:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int m = 0; m < 3; m++) begin
			pp_s6[m]  <= p_s5[m] * $signed({1'b0, radius_q});
			nrm_s6[m] <= nsat[m];
		end
	end

	// stage 7: position rounding and saturation into the output registers
	logic signed [50:0] pv   [3];
	logic signed [24:0] psat [3];
	logic signed [24:0] pos_s7 [3];
	logic signed [15:0] nrm_s7 [3];
	spvg_pkg::cord_side_t sd_s7;

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			pv[m] = (pp_s6[m] + (51'sd1 <<< 21)) >>> 22;
			if (pv[m] > 51'sd16777215)
				psat[m] = 25'sh0FFFFFF;
			else if (pv[m] < -51'sd16777216)
				psat[m] = -25'sh1000000;
			else
				psat[m] = pv[m][24:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_s4 <= '0;
			sd_s5 <= '0;
			sd_s6 <= '0;
			sd_s7 <= '0;
		end else begin
			sd_s4 <= csd_s[CS];
			sd_s5 <= sd_s4;
			sd_s6 <= sd_s5;
			sd_s7 <= sd_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int m = 0; m < 3; m++) begin
			pos_s7[m] <= psat[m];
			nrm_s7[m] <= nrm_s6[m];
		end
	end

	assign done         = sd_s7.valid;
	assign pos_x        = pos_s7[0];
	assign pos_y        = pos_s7[1];
	assign pos_z        = pos_s7[2];
	assign norm_x       = nrm_s7[0];
	assign norm_y       = nrm_s7[1];
	assign norm_z       = nrm_s7[2];
	assign tex_s        = sd_s7.tex_s;
	assign tex_t        = sd_s7.tex_t;
	assign last_of_pair = sd_s7.last;

endmodule
